>>> hdl/r2y420_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package r2y420_pkg;

  // Configuration register widths and reset values
  localparam int unsigned CFG_W = 13;
  localparam int unsigned DEF_MAX_DIM = 4096;
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Fixed-point BT.601 coefficients, 8 fractional bits
  localparam int unsigned ACC_W = 18;
  localparam logic [ACC_W-1:0] KY_R = 18'd66;
  localparam logic [ACC_W-1:0] KY_G = 18'd129;
  localparam logic [ACC_W-1:0] KY_B = 18'd25;
  localparam logic [ACC_W-1:0] K_RND = 18'd128;
  localparam logic [9:0] KY_OFS = 10'd16;
  localparam logic [ACC_W-1:0] KC_112 = 18'd112;
  localparam logic [ACC_W-1:0] KV_G = 18'd94;
  localparam logic [ACC_W-1:0] KV_B = 18'd18;
  localparam logic [ACC_W-1:0] KU_R = 18'd38;
  localparam logic [ACC_W-1:0] KU_G = 18'd74;
  // rounding plus the 128 chroma offset, keeps the chroma sum non-negative
  localparam logic [ACC_W-1:0] KC_BIAS = 18'd32896;

  // red in the lowest bits
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic frame_end;
    logic odd_row;
    logic even_col;
  } pos_t;

  typedef struct packed {
    logic       frame_last;
    logic       chroma_is_v;
    logic       chroma_valid;
    logic [7:0] chroma;
    logic [7:0] luma;
  } res_t;

  function automatic logic [7:0] sat8(input logic [9:0] v);
    logic [7:0] r;
    r = (v > 10'd255) ? 8'd255 : v[7:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rgb24_to_yuv420_convert_core.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB24 to YCbCr 4:2:0 converter, BT.601 studio range. Takes one pixel per clock in
// raster order when not stalled, and returns one beat per pixel: luma always,
// plus a chroma sample on even columns (Cb on even rows, Cr on odd rows). An
// accepted beat lands in the input register at the accepting edge and moves to the
// result register when it is empty or being read out. With m_axis_tready held high
// the block sustains one pixel per clock, since the color math is a single
// combinational pass between the two registers. When both registers hold a beat,
// s_axis_tready follows m_axis_tready combinationally. Column and row counters
// advance on each accepted pixel and wrap at frame_width and frame_height, each
// clamped to MAX_DIM. Sizes may be written whenever no beat is in flight; a change
// in mid-frame keeps the counters, and a counter at or past the new end wraps after
// the current pixel. No clearing pass is needed after reset.
module rgb24_to_yuv420_convert_core #(
  parameter int unsigned MAX_DIM = r2y420_pkg::DEF_MAX_DIM
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  r2y420_pkg::cfg_reg_e             cfg_addr_i,
  input  wire [r2y420_pkg::CFG_W-1:0]      cfg_wdata_i,
  // pixel input
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [23:0]                       s_axis_tdata,  // red, green, blue
  // result output
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // luma, chroma
  output logic [1:0]                       m_axis_tuser,  // chroma_valid, chroma_is_v
  output logic                             m_axis_tlast
);
  import r2y420_pkg::*;

  localparam int unsigned CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DIM_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  logic [CFG_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [DIM_W-1:0] col_nxt, row_nxt;
  logic             line_end, last_row;

  logic  s_acc, s1_adv;
  logic  s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  pix_t  pix_q;
  pos_t  pos_q, pos_d;
  res_t  res_d, res_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = (DIM_W'(width_q) > MAX_DIM_C) ? MAX_DIM_C : DIM_W'(width_q);
  assign height_eff = (DIM_W'(height_q) > MAX_DIM_C) ? MAX_DIM_C : DIM_W'(height_q);

  // ---------------------------------------------------------------- position
  assign col_nxt  = DIM_W'(col_q) + DIM_W'(1);
  assign row_nxt  = DIM_W'(row_q) + DIM_W'(1);
  assign line_end = col_nxt >= width_eff;
  assign last_row = row_nxt >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_acc) begin
      if (line_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_nxt[CNT_W-1:0];
      end else begin
        col_d = col_nxt[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_d.even_col  = ~col_q[0];
  assign pos_d.odd_row   = row_q[0];
  assign pos_d.frame_end = line_end & last_row;

  // ---------------------------------------------------------------- pipeline
  assign s1_adv        = ~s2_vld_q | m_axis_tready;
  assign s_axis_tready = ~s1_vld_q | s1_adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign s1_vld_d      = s_acc | (s1_vld_q & ~s1_adv);
  assign s2_vld_d      = (s1_vld_q & s1_adv) | (s2_vld_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pix_q <= pix_t'(s_axis_tdata);
      pos_q <= pos_d;
    end
    if (s1_vld_q && s1_adv) begin
      res_q <= res_d;
    end
  end

  r2y420_csc u_csc (
    .pix_i (pix_q),
    .pos_i (pos_q),
    .res_o (res_d)
  );

  assign m_axis_tvalid = s2_vld_q;
  assign m_axis_tdata  = {res_q.chroma, res_q.luma};
  assign m_axis_tuser  = {res_q.chroma_is_v, res_q.chroma_valid};
  assign m_axis_tlast  = res_q.frame_last;

  // ---------------------------------------------------------------- checks
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && pos_d.frame_end |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after the last pixel of a frame");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_q.chroma_valid |-> res_q.chroma == 8'd0)
    else $error("chroma not zero on an odd column");

  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.luma >= 8'd16 && res_q.luma <= 8'd235)
    else $error("luma out of studio range");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !line_end |=> col_q == $past(col_nxt[CNT_W-1:0]))
    else $error("column counter did not advance by one");

endmodule

`default_nettype wire

>>> hdl/r2y420_csc.sv
`timescale 1ns / 1ps
`default_nettype none

module r2y420_csc (
  input  r2y420_pkg::pix_t pix_i,
  input  r2y420_pkg::pos_t pos_i,
  output r2y420_pkg::res_t res_o
);
  import r2y420_pkg::*;

  logic [ACC_W-1:0] r_ext;
  logic [ACC_W-1:0] g_ext;
  logic [ACC_W-1:0] b_ext;
  logic [ACC_W-1:0] y_sum;
  logic [ACC_W-1:0] u_sum;
  logic [ACC_W-1:0] v_sum;
  logic [ACC_W-1:0] c_sum;
  logic [9:0]       y_val;

  assign r_ext = ACC_W'(pix_i.red);
  assign g_ext = ACC_W'(pix_i.green);
  assign b_ext = ACC_W'(pix_i.blue);

  assign y_sum = KY_R * r_ext + KY_G * g_ext + KY_B * b_ext + K_RND;
  assign y_val = y_sum[ACC_W-1:8] + KY_OFS;

  // the bias keeps both chroma sums positive, so the shift is a floor
  assign u_sum = KC_112 * b_ext + KC_BIAS - KU_R * r_ext - KU_G * g_ext;
  assign v_sum = KC_112 * r_ext + KC_BIAS - KV_G * g_ext - KV_B * b_ext;
  assign c_sum = pos_i.odd_row ? v_sum : u_sum;

  always_comb begin
    res_o.luma         = sat8(y_val);
    res_o.chroma       = pos_i.even_col ? sat8(c_sum[ACC_W-1:8]) : 8'd0;
    res_o.chroma_valid = pos_i.even_col;
    res_o.chroma_is_v  = pos_i.odd_row;
    res_o.frame_last   = pos_i.frame_end;
  end

endmodule

`default_nettype wire

>>> test/rgb24_to_yuv420_convert_core_test.sv
`timescale 1ns / 1ps

module rgb24_to_yuv420_convert_core_test;
  import r2y420_pkg::*;

  localparam int unsigned DIM_LIMIT = DEF_MAX_DIM;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_reg_e             cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // red, green, blue
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;   // luma, chroma
  logic [1:0]           m_axis_tuser;   // chroma_valid, chroma_is_v
  logic                 m_axis_tlast;

  // predictor state
  logic [CFG_W-1:0]     pred_width;
  logic [CFG_W-1:0]     pred_height;
  int unsigned          pred_col;
  int unsigned          pred_row;
  res_t                 yuv_pending_q[$];

  int unsigned          err_cnt;
  int unsigned          quiet_cycles;
  bit                   tx_idle_en;
  bit                   rx_idle_en;
  bit                   stall_req;

  rgb24_to_yuv420_convert_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
  endfunction

  function automatic logic [7:0] clip8(input int v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // BT.601 studio-range conversion plus raster position tracking
  function automatic res_t predict_yuv(input pix_t p);
    res_t        res;
    int          r;
    int          g;
    int          b;
    int unsigned w;
    int unsigned h;
    bit          line_end;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    w = clamp_dim(pred_width);
    h = clamp_dim(pred_height);
    line_end = (pred_col + 1 >= w);
    res = '0;
    res.luma = clip8(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    res.chroma_valid = (pred_col[0] == 1'b0);
    res.chroma_is_v = pred_row[0];
    res.frame_last = line_end && (pred_row + 1 >= h);
    if (res.chroma_valid) begin
      // bias of 128 + 128*256 keeps the sum positive
      if (res.chroma_is_v) res.chroma = clip8((112 * r + 32896 - 94 * g - 18 * b) >>> 8);
      else res.chroma = clip8((112 * b + 32896 - 38 * r - 74 * g) >>> 8);
    end
    if (line_end) begin
      pred_col = 0;
      pred_row = (pred_row + 1 >= h) ? 0 : pred_row + 1;
    end else begin
      pred_col = pred_col + 1;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // output monitor
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (yuv_pending_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual %h/%b/%b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        err_cnt++;
      end else begin
        exp_r = yuv_pending_q.pop_front();
        check_field("luma", exp_r.luma, m_axis_tdata[7:0]);
        check_field("chroma", exp_r.chroma, m_axis_tdata[15:8]);
        check_field("chroma_valid", exp_r.chroma_valid, m_axis_tuser[0]);
        check_field("chroma_is_v", exp_r.chroma_is_v, m_axis_tuser[1]);
        check_field("frame_last", exp_r.frame_last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rgb24_to_yuv420_convert_core_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stall bursts, plus one long hold on request
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // valid stays high after a beat so back-to-back calls stream without a bubble unless tx_idle_en adds a gap
  task automatic send_pixel(input pix_t p);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    yuv_pending_q.push_back(predict_yuv(p));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (yuv_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) pred_width = val;
    else pred_height = val;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_cfg(REG_FRAME_WIDTH, w);
    write_cfg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [7:0] rand_component();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.red = rand_component();
    p.green = rand_component();
    p.blue = rand_component();
    return p;
  endfunction

  // mostly small frames so wraps are frequent; a few oversize and degenerate ones
  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(0, 15))
      0: return CFG_W'($urandom_range(0, 1));
      1: return CFG_W'($urandom_range(DIM_LIMIT + 1, 8191));
      2: return CFG_W'($urandom_range(17, DIM_LIMIT));
      default: return CFG_W'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic test_reset_geometry();
    send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd0});
    send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255});
    send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd255});
    send_pixel('{blue: 8'd0, green: 8'd255, red: 8'd0});
    send_pixel('{blue: 8'd255, green: 8'd0, red: 8'd0});
    send_pixel('{blue: 8'd0, green: 8'd255, red: 8'd255});
    send_pixel('{blue: 8'd255, green: 8'd0, red: 8'd255});
    send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd0});
  endtask

  task automatic test_small_frames();
    set_frame(13'd2, 13'd2);
    repeat (6) send_pixel(rand_pixel());
    // single pixel and zero sizes: every pixel ends a frame
    set_frame(13'd1, 13'd1);
    repeat (3) send_pixel(rand_pixel());
    set_frame(13'd0, 13'd0);
    repeat (2) send_pixel(rand_pixel());
  endtask

  task automatic test_resize_mid_frame();
    set_frame(13'd8, 13'd4);
    repeat (5) send_pixel(rand_pixel());
    // column is now past the new line end, wraps after the next pixel
    write_cfg(REG_FRAME_WIDTH, 13'd3);
    repeat (4) send_pixel(rand_pixel());
  endtask

  task automatic test_oversize_frame();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_frame(13'h1fff, 13'd1);
    repeat (40) send_pixel(rand_pixel());
    set_frame(13'd1, 13'h1fff);
    repeat (40) send_pixel(rand_pixel());
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < 600) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: write_cfg(REG_FRAME_WIDTH, rand_dim());
        1: write_cfg(REG_FRAME_HEIGHT, rand_dim());
        default: set_frame(rand_dim(), rand_dim());
      endcase
      burst = $urandom_range(10, 60);
      repeat (burst) send_pixel(rand_pixel());
      sent += burst;
    end
  endtask

  task automatic test_output_stall();
    set_frame(13'd6, 13'd3);
    tx_idle_en = 1'b0;
    stall_req = 1'b1;
    repeat (40) send_pixel(rand_pixel());
  endtask

  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_frame(13'd4, 13'd3);
    repeat (90) send_pixel(rand_pixel());
    set_frame(13'd10, 13'd5);
    repeat (90) send_pixel(rand_pixel());
  endtask

  initial begin
    err_cnt = 0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stall_req = 1'b0;
    pred_width = RST_FRAME_WIDTH;
    pred_height = RST_FRAME_HEIGHT;
    pred_col = 0;
    pred_row = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= REG_FRAME_WIDTH;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reset_geometry();
    test_small_frames();
    test_resize_mid_frame();
    test_oversize_frame();
    test_random_traffic();
    test_output_stall();
    test_steady_stream();

    wait_idle();
    if (err_cnt == 0) begin
      $display("rgb24_to_yuv420_convert_core_test: clean");
    end else begin
      $display("rgb24_to_yuv420_convert_core_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/r2y420_pkg.sv
hdl/r2y420_csc.sv
hdl/rgb24_to_yuv420_convert_core.sv
test/rgb24_to_yuv420_convert_core_test.sv
